// File: hdl/hbpa_pkg.sv
`default_nettype none
package hbpa_pkg;

	localparam int DEF_BASE_BLOCKS = 4096;
	localparam int DEF_NUM_LEVELS  = 8;
	localparam int WORD_BITS       = 32;
	localparam int REQ_W           = 2;
	localparam int GRAN_W          = 3;
	localparam int INDEX_W         = 12;
	localparam int PAGE_W          = 12;

	localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
	localparam logic [REQ_W-1:0] REQ_MARK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FREE  = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NOP   = 2'd3;

	localparam logic ST_OK   = 1'b0;
	localparam logic ST_FULL = 1'b1;

	typedef struct packed {
		logic [REQ_W-1:0]   req_type;
		logic [GRAN_W-1:0]  granularity;
		logic [INDEX_W-1:0] block_index;
	} req_t;

	typedef struct packed {
		logic [PAGE_W-1:0] base_page;
		logic              status;
	} res_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FILL_INIT,
		S_FILL_RD,
		S_FILL_WR,
		S_ANC_RD,
		S_ANC_WR,
		S_REL_RDA,
		S_REL_RDB,
		S_REL_RDP,
		S_REL_WR,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// File: hdl/hbpa_core.sv
`default_nettype none
module hbpa_core #(
	parameter int BASE_BLOCKS = hbpa_pkg::DEF_BASE_BLOCKS,
	parameter int NUM_LEVELS  = hbpa_pkg::DEF_NUM_LEVELS
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire hbpa_pkg::req_t req,
	input  wire logic          req_valid,
	output logic               req_ready,
	output hbpa_pkg::res_t     res,
	output logic               res_valid,
	input  wire logic          res_ready
);
	import hbpa_pkg::*;

	localparam int PW = $clog2(2 * BASE_BLOCKS);
	localparam int AW = PW - 5;
	localparam int NW = 1 << AW;
	localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
	localparam int KW = $clog2(NUM_LEVELS + 1);
	localparam int IW = $clog2(BASE_BLOCKS);

	function automatic logic [PW-1:0] base_of(input int k);
		int s;
		int j;
		s = 0;
		for (j = 0; j < k; j++) begin
			s = s + (BASE_BLOCKS >> j);
		end
		return PW'(s);
	endfunction

	function automatic logic [WORD_BITS-1:0] range_mask(input logic [AW-1:0] w,
			input logic [PW-1:0] lo, input logic [PW-1:0] hi);
		logic [WORD_BITS-1:0] m;
		logic [PW-1:0]        p;
		int                   b;
		for (b = 0; b < WORD_BITS; b++) begin
			p = {w, 5'(b)};
			m[b] = (p >= lo) && (p <= hi);
		end
		return m;
	endfunction

	function automatic logic [4:0] lowest_one(input logic [WORD_BITS-1:0] v);
		logic [4:0] r;
		int         b;
		r = '0;
		for (b = WORD_BITS - 1; b >= 0; b--) begin
			if (v[b]) begin
				r = 5'(b);
			end
		end
		return r;
	endfunction

	logic [PW-1:0] lvl_base [NUM_LEVELS];
	logic [PW-1:0] lvl_size [NUM_LEVELS];

	for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_tab
		assign lvl_base[g] = base_of(g);
		assign lvl_size[g] = PW'(BASE_BLOCKS >> g);
	end

	state_t                state_q, state_d;
	logic [AW-1:0]         clr_q;
	logic [REQ_W-1:0]      op_q;
	logic [LW-1:0]         lvl_q;
	logic [LW-1:0]         fk_q;
	logic [KW-1:0]         kk_q;
	logic [IW-1:0]         idx_q;
	logic [AW-1:0]         fw_q;
	logic [AW-1:0]         sw_q;
	logic [AW-1:0]         sw_s1;
	logic                  sv_s1;
	logic                  bita_q;
	logic [PAGE_W-1:0]     base_q;
	logic                  status_q;
	logic [WORD_BITS-1:0]  mem_q [NW];
	logic [WORD_BITS-1:0]  rd_q;

	logic                  rd_en, wr_en;
	logic [AW-1:0]         rd_addr, wr_addr;
	logic [WORD_BITS-1:0]  wr_data;

	logic                  g_ok, in_range;
	logic [LW-1:0]         gsel;
	logic [PW-1:0]         g_base;
	logic [LW-1:0]         sh;
	logic [PW-1:0]         f_start, f_end;
	logic [WORD_BITS-1:0]  f_mask;
	logic                  fill_set;
	logic [PW-1:0]         s_lb, s_le;
	logic [WORD_BITS-1:0]  s_free;
	logic                  s_found;
	logic [PW-1:0]         s_idx;
	logic [31:0]           s_page;
	logic [PW-1:0]         pp, cp, cp1;
	logic [LW-1:0]         kk_lvl, kkm1;
	logic [KW-1:0]         kk_first, kk_next;
	logic                  rel_bitb;

	assign g_ok     = {29'd0, req.granularity} < NUM_LEVELS;
	assign gsel     = g_ok ? LW'(req.granularity) : '0;
	assign g_base   = lvl_base[gsel];
	assign in_range = {20'd0, req.block_index} < 32'(lvl_size[gsel]);

	assign sh       = lvl_q - fk_q;
	assign f_start  = lvl_base[fk_q] + (PW'(idx_q) << sh);
	assign f_end    = f_start + (PW'(1) << sh) - PW'(1);
	assign f_mask   = range_mask(fw_q, f_start, f_end);
	assign fill_set = (op_q != REQ_FREE);

	assign s_lb     = lvl_base[lvl_q];
	assign s_le     = s_lb + lvl_size[lvl_q] - PW'(1);
	assign s_free   = ~rd_q & range_mask(sw_s1, s_lb, s_le);
	assign s_found  = |s_free;
	assign s_idx    = {sw_s1, lowest_one(s_free)} - s_lb;
	assign s_page   = 32'(s_idx) << lvl_q;

	assign kk_lvl   = kk_q[LW-1:0];
	assign kkm1     = kk_lvl - LW'(1);
	assign kk_first = KW'(lvl_q) + KW'(1);
	assign kk_next  = kk_q + KW'(1);
	assign pp       = lvl_base[kk_lvl] + PW'(idx_q >> 1);
	assign cp       = lvl_base[kkm1] + PW'({idx_q[IW-1:1], 1'b0});
	assign cp1      = cp + PW'(1);
	assign rel_bitb = rd_q[cp1[4:0]];

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_q == AW'(NW - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					if (req.req_type == REQ_NOP || !g_ok) begin
						state_d = S_DONE;
					end else if (req.req_type == REQ_ALLOC) begin
						state_d = (lvl_size[gsel] == '0) ? S_DONE : S_SCAN;
					end else if (!in_range) begin
						state_d = S_DONE;
					end else begin
						state_d = S_FILL_INIT;
					end
				end
			end
			S_SCAN: begin
				if (sv_s1 && s_found) begin
					state_d = S_FILL_INIT;
				end else if (sv_s1 && sw_s1 == s_le[PW-1:5]) begin
					state_d = S_DONE;
				end
			end
			S_FILL_INIT: state_d = S_FILL_RD;
			S_FILL_RD:   state_d = S_FILL_WR;
			S_FILL_WR: begin
				if (fw_q != f_end[PW-1:5]) begin
					state_d = S_FILL_RD;
				end else if (fk_q != '0) begin
					state_d = S_FILL_INIT;
				end else if (kk_first >= KW'(NUM_LEVELS)) begin
					state_d = S_DONE;
				end else begin
					state_d = fill_set ? S_ANC_RD : S_REL_RDA;
				end
			end
			S_ANC_RD: state_d = S_ANC_WR;
			S_ANC_WR: state_d = (kk_next == KW'(NUM_LEVELS)) ? S_DONE : S_ANC_RD;
			S_REL_RDA: state_d = S_REL_RDB;
			S_REL_RDB: state_d = S_REL_RDP;
			S_REL_RDP: state_d = (bita_q || rel_bitb) ? S_DONE : S_REL_WR;
			S_REL_WR: state_d = (kk_next == KW'(NUM_LEVELS)) ? S_DONE : S_REL_RDA;
			S_DONE: begin
				if (res_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		rd_en     = 1'b0;
		rd_addr   = '0;
		wr_en     = 1'b0;
		wr_addr   = '0;
		wr_data   = '0;
		req_ready = 1'b0;
		res_valid = 1'b0;
		case (state_q)
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
			end
			S_IDLE: req_ready = 1'b1;
			S_SCAN: begin
				rd_en   = 1'b1;
				rd_addr = sw_q;
			end
			S_FILL_RD: begin
				rd_en   = 1'b1;
				rd_addr = fw_q;
			end
			S_FILL_WR: begin
				wr_en   = 1'b1;
				wr_addr = fw_q;
				wr_data = fill_set ? (rd_q | f_mask) : (rd_q & ~f_mask);
			end
			S_ANC_RD: begin
				rd_en   = 1'b1;
				rd_addr = pp[PW-1:5];
			end
			S_ANC_WR: begin
				wr_en   = 1'b1;
				wr_addr = pp[PW-1:5];
				wr_data = rd_q | (WORD_BITS'(1) << pp[4:0]);
			end
			S_REL_RDA: begin
				rd_en   = 1'b1;
				rd_addr = cp[PW-1:5];
			end
			S_REL_RDB: begin
				rd_en   = 1'b1;
				rd_addr = cp1[PW-1:5];
			end
			S_REL_RDP: begin
				rd_en   = 1'b1;
				rd_addr = pp[PW-1:5];
			end
			S_REL_WR: begin
				wr_en   = 1'b1;
				wr_addr = pp[PW-1:5];
				wr_data = rd_q & ~(WORD_BITS'(1) << pp[4:0]);
			end
			S_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res.base_page = base_q;
	assign res.status    = status_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			sv_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_CLEAR) clr_q <= clr_q + AW'(1);
			sv_s1 <= (state_q == S_SCAN);
		end
	end

	always_ff @(posedge clk) begin
		sw_s1 <= sw_q;
		case (state_q)
			S_IDLE: begin
				op_q     <= req.req_type;
				lvl_q    <= gsel;
				fk_q     <= gsel;
				idx_q    <= IW'(req.block_index);
				sw_q     <= g_base[PW-1:5];
				base_q   <= '0;
				status_q <= (req.req_type != REQ_NOP)
					&& (!g_ok || lvl_size[gsel] == '0
						|| (req.req_type != REQ_ALLOC && !in_range));
			end
			S_SCAN: begin
				sw_q <= sw_q + AW'(1);
				if (sv_s1 && s_found) begin
					idx_q  <= IW'(s_idx);
					base_q <= s_page[PAGE_W-1:0];
				end else if (sv_s1 && sw_s1 == s_le[PW-1:5]) begin
					status_q <= ST_FULL;
				end
			end
			S_FILL_INIT: fw_q <= f_start[PW-1:5];
			S_FILL_WR: begin
				fw_q <= fw_q + AW'(1);
				if (fw_q == f_end[PW-1:5] && fk_q != '0) fk_q <= fk_q - LW'(1);
				kk_q <= kk_first;
			end
			S_REL_RDB: bita_q <= rd_q[cp[4:0]];
			S_ANC_WR, S_REL_WR: begin
				idx_q <= idx_q >> 1;
				kk_q  <= kk_next;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// File: hdl/hierarchical_bitmap_page_allocator.sv
// Page allocator over a multi-level usage bitmap.
// Input stream (s_axis): one request per transaction; tuser carries the
// request kind (allocate, mark used, free, no-op), tdata the level and block index.
// Output stream (m_axis): exactly one result per request, in order, holding
// the allocated block's first base page and a status flag (set when the
// level is full or the request is rejected).
// The bitmap sits in one synchronous single-read, single-write memory of
// 2*BASE_BLOCKS/32 words. Each request is a sequence of read-modify-write
// steps: an allocate scans one word per cycle over its level, then marking
// reads and writes each subtree word, level by level, and then sets each
// ancestor bit; a free clears the subtree the same way, then for each
// ancestor reads both children and the parent and clears the parent bit,
// stopping at the first ancestor with a child still in use. One request is
// in work at a time; accept and result hand-off are steps of their own.
// After reset the memory is swept to zero, one word per cycle over all
// 2*BASE_BLOCKS/32 words (256 at the default size); s_axis_tready stays low
// meanwhile. A finished result waits in the output register; while that is
// full and m_axis stalls, the engine holds its last step, accepting nothing.
`default_nettype none
module hierarchical_bitmap_page_allocator #(
	parameter int BASE_BLOCKS = hbpa_pkg::DEF_BASE_BLOCKS,
	parameter int NUM_LEVELS  = hbpa_pkg::DEF_NUM_LEVELS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // granularity[2:0], block_index[14:3]
	input  wire logic [1:0]  s_axis_tuser,  // req_type[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata   // base_page[11:0], status[12]
);
	import hbpa_pkg::*;

	req_t  req;
	res_t  res;
	logic  res_valid, res_ready;
	logic  out_valid_q;
	res_t  out_q;

	assign req.req_type    = s_axis_tuser;
	assign req.granularity = s_axis_tdata[2:0];
	assign req.block_index = s_axis_tdata[14:3];

	assign res_ready = !out_valid_q || m_axis_tready;

	hbpa_core #(
		.BASE_BLOCKS (BASE_BLOCKS),
		.NUM_LEVELS  (NUM_LEVELS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) out_q <= res;
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'd0, out_q.status, out_q.base_page};

endmodule
`default_nettype wire

// File: tb/hierarchical_bitmap_page_allocator_test.sv
module hierarchical_bitmap_page_allocator_test;
	import hbpa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BLOCKS = DEF_BASE_BLOCKS;
	localparam int LEVELS = DEF_NUM_LEVELS;
	localparam int RANDOM_REQS = 1200;
	localparam int IDLE_LIMIT = 40000;
	localparam int DRAIN_CYCLES = 400;

	typedef struct {
		logic [REQ_W-1:0]   req;
		logic [GRAN_W-1:0]  gran;
		logic [INDEX_W-1:0] idx;
		bit                 typed;
		logic [PAGE_W-1:0]  page;
		logic               status;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;

	logic [2*BLOCKS-1:0] used_map;
	res_t pending_results[$];
	int errors = 0;
	int idle_cycles = 0;
	int burst_left = 0;
	int n_alloc = 0, n_full = 0, n_mark = 0, n_free = 0, n_reject = 0, n_nop = 0;

	hierarchical_bitmap_page_allocator DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int level_start(int lvl);
		int sum = 0;
		for (int k = 0; k < lvl; k++) sum += BLOCKS >> k;
		return sum;
	endfunction

	function automatic void paint_subtree(int lvl, int idx, logic v);
		for (int k = 0; k <= lvl; k++) begin
			for (int j = 0; j < (1 << (lvl - k)); j++)
				used_map[level_start(k) + (idx << (lvl - k)) + j] = v;
		end
	endfunction

	function automatic void claim_block(int lvl, int idx);
		paint_subtree(lvl, idx, 1'b1);
		for (int k = lvl + 1; k < LEVELS; k++) begin
			idx = idx >> 1;
			used_map[level_start(k) + idx] = 1'b1;
		end
	endfunction

	function automatic void release_block(int lvl, int idx);
		int child;
		paint_subtree(lvl, idx, 1'b0);
		for (int k = lvl + 1; k < LEVELS; k++) begin
			child = level_start(k - 1) + ((idx >> 1) << 1);
			idx = idx >> 1;
			if (used_map[child] || used_map[child + 1]) break;
			used_map[level_start(k) + idx] = 1'b0;
		end
	endfunction

	function automatic res_t allocate_page(logic [REQ_W-1:0] req, int lvl, int idx);
		res_t r;
		r.base_page = '0;
		r.status = ST_OK;
		if (req == REQ_NOP) begin
			n_nop++;
		end else if (lvl >= LEVELS) begin
			r.status = ST_FULL;
		end else if (req == REQ_ALLOC) begin
			r.status = ST_FULL;
			for (int i = 0; i < (BLOCKS >> lvl); i++) begin
				if (!used_map[level_start(lvl) + i]) begin
					claim_block(lvl, i);
					r.base_page = PAGE_W'(i << lvl);
					r.status = ST_OK;
					break;
				end
			end
			if (r.status == ST_FULL) n_full++; else n_alloc++;
		end else if (idx >= (BLOCKS >> lvl)) begin
			r.status = ST_FULL;
			n_reject++;
		end else if (req == REQ_MARK) begin
			claim_block(lvl, idx);
			n_mark++;
		end else begin
			release_block(lvl, idx);
			n_free++;
		end
		return r;
	endfunction

	task automatic send_request(row_t row);
		res_t r;
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= row.req;
		s_axis_tdata <= {1'b0, row.idx, row.gran};
		do @(posedge clk); while (!s_axis_tready);
		r = allocate_page(row.req, row.gran, row.idx);
		if (row.typed) begin
			r.base_page = row.page;
			r.status = row.status;
		end
		pending_results.push_back(r);
	endtask

	function automatic row_t random_row();
		row_t row;
		int pick = $urandom_range(0, 99);
		int g = (pick < 50) ? $urandom_range(0, 7) : $urandom_range(4, 7);
		row.typed = 0;
		row.page = '0;
		row.status = ST_OK;
		row.gran = GRAN_W'(g);
		if (pick < 40) begin
			row.req = REQ_ALLOC;
			row.idx = INDEX_W'($urandom_range(0, 4095));
		end else if (pick < 88) begin
			row.req = (pick < 60) ? REQ_MARK : REQ_FREE;
			row.idx = INDEX_W'($urandom_range(0, (BLOCKS >> g) - 1));
		end else if (pick < 96) begin
			row.req = (pick[0]) ? REQ_MARK : REQ_FREE;
			if (g == 0) row.gran = 3'd1;
			row.idx = INDEX_W'($urandom_range(BLOCKS >> row.gran, 4095));
		end else begin
			row.req = REQ_NOP;
			row.idx = INDEX_W'($urandom_range(0, 4095));
		end
		return row;
	endfunction

	row_t directed[] = '{
		'{REQ_ALLOC, 3'd0, 12'd0,    1, 12'd0,   ST_OK},
		'{REQ_ALLOC, 3'd7, 12'd4095, 1, 12'd128, ST_OK},
		'{REQ_ALLOC, 3'd0, 12'd0,    1, 12'd1,   ST_OK},
		'{REQ_MARK,  3'd7, 12'd31,   1, 12'd0,   ST_OK},
		'{REQ_MARK,  3'd3, 12'd4095, 1, 12'd0,   ST_FULL},
		'{REQ_FREE,  3'd7, 12'd32,   1, 12'd0,   ST_FULL},
		'{REQ_MARK,  3'd0, 12'd4095, 1, 12'd0,   ST_OK},
		'{REQ_FREE,  3'd0, 12'd4095, 1, 12'd0,   ST_OK},
		'{REQ_NOP,   3'd5, 12'd4095, 1, 12'd0,   ST_OK},
		'{REQ_NOP,   3'd0, 12'd0,    1, 12'd0,   ST_OK},
		'{REQ_MARK,  3'd7, 12'd0,    0, 12'd0,   ST_OK},
		'{REQ_FREE,  3'd3, 12'd0,    0, 12'd0,   ST_OK},
		'{REQ_ALLOC, 3'd2, 12'd0,    0, 12'd0,   ST_OK},
		'{REQ_FREE,  3'd0, 12'd1,    0, 12'd0,   ST_OK},
		'{REQ_FREE,  3'd7, 12'd0,    0, 12'd0,   ST_OK},
		'{REQ_ALLOC, 3'd6, 12'd0,    0, 12'd0,   ST_OK},
		'{REQ_MARK,  3'd1, 12'd2047, 0, 12'd0,   ST_OK},
		'{REQ_FREE,  3'd1, 12'd2048, 1, 12'd0,   ST_FULL},
		'{REQ_FREE,  3'd7, 12'd31,   0, 12'd0,   ST_OK},
		'{REQ_FREE,  3'd7, 12'd1,    0, 12'd0,   ST_OK}
	};

	initial begin
		row_t row;
		used_map = '0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		foreach (directed[i]) send_request(directed[i]);
		for (int n = 0; n < RANDOM_REQS; n++) begin
			if (n % 300 == 150) begin
				for (int k = 0; k < 36; k++) begin
					row = random_row();
					row.req = REQ_ALLOC;
					row.gran = 3'd7;
					send_request(row);
				end
			end else if (n % 300 == 299) begin
				for (int k = 0; k < 32; k++) begin
					row = random_row();
					row.req = REQ_FREE;
					row.gran = 3'd7;
					row.idx = INDEX_W'(k);
					send_request(row);
				end
			end else begin
				send_request(random_row());
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() > 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() > 0) begin
			$display("%0t: %0d results never arrived", $realtime, pending_results.size());
			errors++;
		end
		$display("Covered %0d allocations, %0d full levels, %0d marks, %0d frees,",
			n_alloc, n_full, n_mark, n_free);
		$display("%0d rejected indexes and %0d ignored requests, with stalls on both sides.",
			n_reject, n_nop);
		if (errors == 0)
			$display("hierarchical_bitmap_page_allocator test passed");
		else
			$display("hierarchical_bitmap_page_allocator test failed");
		$finish;
	end

	initial begin
		int cycle = 0;
		forever begin
			@(negedge clk);
			cycle++;
			if (cycle == 6000) begin
				m_axis_tready <= 1'b0;
				repeat (3000) @(negedge clk);
				cycle++;
			end else if ((cycle / 64) % 4 == 3) begin
				m_axis_tready <= 1'b1;
			end else begin
				m_axis_tready <= ($urandom_range(0, 2) != 0);
			end
		end
	end

	always @(posedge clk) begin
		res_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $realtime, m_axis_tdata);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (m_axis_tdata[11:0] !== want.base_page) begin
					$display("%0t: base_page expected %0d actual %0d", $realtime,
						want.base_page, m_axis_tdata[11:0]);
					errors++;
				end
				if (m_axis_tdata[12] !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $realtime,
						want.status, m_axis_tdata[12]);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("%0t: timeout, no transaction for %0d cycles", $realtime, idle_cycles);
			$display("hierarchical_bitmap_page_allocator test failed");
			$finish;
		end
	end
endmodule
